// ===== hw/rtl/rbs_pkg.sv =====
// types, codes and backoff table shared by the reconnect backoff scheduler
package rbs_pkg;

    localparam int unsigned TIME_W   = 48;
    localparam int unsigned DL_W     = 49;
    localparam int unsigned WIN_W    = 32;
    localparam int unsigned CNT_W    = 32;
    localparam int unsigned STAGE_W  = 4;
    localparam int unsigned GEN_W    = 48;
    localparam int unsigned BOFF_W   = 14;
    localparam int unsigned CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE       = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_STAGE_WINDOW = 1'b1;

    localparam logic [STAGE_W-1:0] STAGE_IDLE          = 4'd0;
    localparam logic [STAGE_W-1:0] STAGE_REQUEST_READY = 4'd1;
    localparam logic [STAGE_W-1:0] STAGE_CONNECTED     = 4'd10;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    typedef enum logic [1:0] {
        ACT_NONE      = 2'd0,
        ACT_FAILED    = 2'd1,
        ACT_SCHEDULED = 2'd2,
        ACT_REBUILD   = 2'd3
    } t_action;

    typedef struct packed {
        logic               enable;
        logic [WIN_W-1:0]   stage_window;
    } t_cfg;

    typedef struct packed {
        logic               req_type;
        logic [TIME_W-1:0]  now_time;
        logic               link_failed;
        logic [STAGE_W-1:0] next_stage;
        logic [GEN_W-1:0]   next_gen;
    } t_event;

    typedef struct packed {
        logic    progress_ok;
        t_action action;
    } t_result;

    // backoff in ms, capped at the last table entry
    function automatic logic [BOFF_W-1:0] rbs_backoff(input logic [CNT_W-1:0] count);
        logic [2:0] idx;
        logic [BOFF_W-1:0] ms;
        idx = (count < CNT_W'(4)) ? {1'b0, count[1:0]} : 3'd4;
        case (idx)
            3'd0:    ms = 14'd1000;
            3'd1:    ms = 14'd2000;
            3'd2:    ms = 14'd4000;
            3'd3:    ms = 14'd8000;
            default: ms = 14'd16000;
        endcase
        return ms;
    endfunction

endpackage

// ===== hw/rtl/rbs_engine.sv =====
// scheduler state and combinational decision logic for one event
module rbs_engine
    import rbs_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  logic    i_evt_valid,
    input  t_event  i_evt,
    output t_result o_res
);

    logic               r_busy;
    logic [DL_W-1:0]    r_stage_deadline;
    logic [DL_W-1:0]    r_overall_deadline;
    logic [DL_W-1:0]    r_retry_time;
    logic [CNT_W-1:0]   r_attempts;
    logic [STAGE_W-1:0] r_stage;
    logic [GEN_W-1:0]   r_gen;

    logic               n_busy;
    logic [DL_W-1:0]    n_stage_deadline;
    logic [DL_W-1:0]    n_overall_deadline;
    logic [DL_W-1:0]    n_retry_time;
    logic [CNT_W-1:0]   n_attempts;
    logic [STAGE_W-1:0] n_stage;
    logic [GEN_W-1:0]   n_gen;

    logic [DL_W-1:0] now_ext;
    logic [DL_W-1:0] retry_at;
    logic [DL_W-1:0] stage_limit;
    logic [DL_W-1:0] overall_limit;
    logic            past_stage_dl;
    logic            prog_ok;

    assign now_ext       = {1'b0, i_evt.now_time};
    assign retry_at      = now_ext + DL_W'(rbs_backoff(r_attempts));
    assign stage_limit   = now_ext + DL_W'(i_cfg.stage_window);
    assign overall_limit = now_ext + DL_W'({i_cfg.stage_window, 2'b00});
    assign past_stage_dl = now_ext >= r_stage_deadline;

    assign prog_ok = i_cfg.enable && r_busy && !past_stage_dl
                     && (i_evt.next_gen != '0)
                     && ((r_gen == '0) || (i_evt.next_gen == r_gen))
                     && (i_evt.next_stage > r_stage)
                     && (i_evt.next_stage < STAGE_CONNECTED);

    always_comb begin
        n_busy             = r_busy;
        n_stage_deadline   = r_stage_deadline;
        n_overall_deadline = r_overall_deadline;
        n_retry_time       = r_retry_time;
        n_attempts         = r_attempts;
        n_stage            = r_stage;
        n_gen              = r_gen;
        o_res.progress_ok  = 1'b0;
        o_res.action       = ACT_NONE;
        if (i_evt.req_type) begin
            o_res.progress_ok = prog_ok;
            if (prog_ok) begin
                n_gen   = i_evt.next_gen;
                n_stage = i_evt.next_stage;
                n_stage_deadline = (stage_limit < r_overall_deadline) ? stage_limit
                                                                      : r_overall_deadline;
            end
        end else if (i_cfg.enable && (i_cfg.stage_window != '0)) begin
            if (r_busy) begin
                if (i_evt.link_failed || past_stage_dl) begin
                    n_busy           = 1'b0;
                    n_stage_deadline = '0;
                    n_retry_time     = retry_at;
                    o_res.action     = ACT_FAILED;
                end
            end else if (r_retry_time == '0) begin
                n_retry_time = retry_at;
                o_res.action = ACT_SCHEDULED;
            end else if (now_ext >= r_retry_time) begin
                if (r_attempts != CNT_MAX) begin
                    n_attempts = r_attempts + CNT_W'(1);
                end
                n_retry_time       = '0;
                n_busy             = 1'b1;
                n_stage_deadline   = stage_limit;
                n_overall_deadline = overall_limit;
                n_stage            = STAGE_REQUEST_READY;
                n_gen              = '0;
                o_res.action       = ACT_REBUILD;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy             <= 1'b0;
            r_stage_deadline   <= '0;
            r_overall_deadline <= '0;
            r_retry_time       <= '0;
            r_attempts         <= '0;
            r_stage            <= STAGE_IDLE;
            r_gen              <= '0;
        end else if (i_evt_valid) begin
            r_busy             <= n_busy;
            r_stage_deadline   <= n_stage_deadline;
            r_overall_deadline <= n_overall_deadline;
            r_retry_time       <= n_retry_time;
            r_attempts         <= n_attempts;
            r_stage            <= n_stage;
            r_gen              <= n_gen;
        end
    end

    a_attempts_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> r_attempts >= $past(r_attempts))
        else $error("attempt count went down");

    a_busy_unscheduled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_retry_time == '0)
        else $error("retry scheduled while an attempt is in flight");

    a_rebuild_sets_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_evt_valid && (o_res.action == ACT_REBUILD) |=> r_busy)
        else $error("rebuild did not start an attempt");

    a_deadline_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_stage_deadline <= r_overall_deadline)
        else $error("stage deadline past overall deadline");

endmodule

// ===== hw/rtl/reconnect_backoff_scheduler.sv =====
// reconnect retry scheduler with capped exponential backoff, stream top level
//
// Usage: events enter on the s_axis channel, one result per event leaves on
// the m_axis channel in the same order. s_axis_tuser selects a tick (0) or a
// progress observation (1); tdata carries time, link failure, phase and
// generation. m_axis_tdata carries the tick action and the progress verdict.
// Configuration (enable, stage window) is written through i_cfg_we/addr/wdata; the
// user must do so while no event is in flight (not enforced by the block). A write
// takes effect at the next clock edge. An accepted transfer waits in the input
// register until the output register is free or read, then is decided and registered
// there for m_axis. One event per cycle is taken while the receiver does not stall;
// each is one pass of adds and compares on the scheduler state the prior one left.
// Reset clears the schedule state and both registers (schedule disabled).
// When the receiver stalls, the result stays in the output register and one
// further event is held in the input register; s_axis_tready then drops.
module reconnect_backoff_scheduler
    import rbs_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_addr,
    input  logic [WIN_W-1:0]     i_cfg_wdata,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // now_time[47:0], link_failed[48], next_stage[52:49], next_gen[100:53], zero pad
    input  logic [103:0]         s_axis_tdata,
    // req_type
    input  logic                 s_axis_tuser,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // action[1:0], progress_ok[2], zero pad
    output logic [7:0]           m_axis_tdata
);

    t_cfg    r_cfg;
    logic    r_in_valid;
    t_event  r_in;
    logic    r_out_valid;
    t_result r_out;
    t_result res;
    logic    advance;

    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_ENABLE:       r_cfg.enable       <= i_cfg_wdata[0];
                CFG_STAGE_WINDOW: r_cfg.stage_window <= i_cfg_wdata;
                default:          r_cfg              <= r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in.req_type    <= s_axis_tuser;
            r_in.now_time    <= s_axis_tdata[47:0];
            r_in.link_failed <= s_axis_tdata[48];
            r_in.next_stage  <= s_axis_tdata[52:49];
            r_in.next_gen    <= s_axis_tdata[100:53];
        end
    end

    rbs_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_evt_valid (advance),
        .i_evt       (r_in),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'b0, r_out.progress_ok, r_out.action};

    a_progress_no_action: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out.progress_ok && (r_out.action != ACT_NONE)))
        else $error("result carries both a tick action and a progress verdict");

    a_advance_delivers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_valid)
        else $error("decided event produced no result");

endmodule

// ===== dv/testbench.sv =====
// self-checking stream testbench for the reconnect backoff scheduler
module testbench;
    import rbs_pkg::*;

    localparam logic KIND_TICK     = 1'b0;
    localparam logic KIND_PROGRESS = 1'b1;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_addr = '0;
    logic [WIN_W-1:0]     i_cfg_wdata = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    // now_time[47:0], link_failed[48], next_stage[52:49], next_gen[100:53], zero pad
    logic [103:0]         s_axis_tdata = '0;
    // req_type
    logic                 s_axis_tuser = 1'b0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    // action[1:0], progress_ok[2], zero pad
    logic [7:0]           m_axis_tdata;

    reconnect_backoff_scheduler dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // scheduler mirror
    logic              cfg_en = 1'b0;
    logic [WIN_W-1:0]  cfg_win = '0;
    logic              busy = 1'b0;
    logic [DL_W-1:0]   stage_dl = '0;
    logic [DL_W-1:0]   overall_dl = '0;
    logic [DL_W-1:0]   retry_at = '0;
    logic [CNT_W-1:0]  attempts = '0;
    logic [STAGE_W-1:0] cur_stage = '0;
    logic [GEN_W-1:0]  cur_gen = '0;

    t_event  event_q[$];
    t_result verdict_q[$];
    t_event  drv_ev;
    int      n_queued = 0;
    int      err_count = 0;
    int      send_idle = 0;
    int      recv_idle = 0;
    logic [TIME_W-1:0] tc = '0;

    function automatic logic [DL_W-1:0] retry_gap();
        return (attempts >= CNT_W'(4)) ? DL_W'(16000) : (DL_W'(1000) << attempts[1:0]);
    endfunction

    function automatic t_result schedule_event(input t_event ev);
        t_result r;
        logic [DL_W-1:0] now49;
        logic [DL_W-1:0] lim;
        r.action = ACT_NONE;
        r.progress_ok = 1'b0;
        now49 = {1'b0, ev.now_time};
        if (!cfg_en)
            return r;
        if (ev.req_type == KIND_PROGRESS) begin
            if (busy && now49 < stage_dl && ev.next_gen != '0
                && (cur_gen == '0 || ev.next_gen == cur_gen)
                && ev.next_stage > cur_stage && ev.next_stage < STAGE_CONNECTED) begin
                cur_gen = ev.next_gen;
                cur_stage = ev.next_stage;
                lim = now49 + DL_W'(cfg_win);
                stage_dl = (lim < overall_dl) ? lim : overall_dl;
                r.progress_ok = 1'b1;
            end
        end else if (cfg_win != '0) begin
            if (busy && (ev.link_failed || now49 >= stage_dl)) begin
                busy = 1'b0;
                stage_dl = '0;
                retry_at = now49 + retry_gap();
                r.action = ACT_FAILED;
            end else if (!busy) begin
                if (retry_at == '0) begin
                    retry_at = now49 + retry_gap();
                    r.action = ACT_SCHEDULED;
                end else if (now49 >= retry_at) begin
                    if (attempts != CNT_MAX)
                        attempts = attempts + 1'b1;
                    retry_at = '0;
                    busy = 1'b1;
                    stage_dl = now49 + DL_W'(cfg_win);
                    overall_dl = now49 + (DL_W'(cfg_win) << 2);
                    cur_stage = STAGE_REQUEST_READY;
                    cur_gen = '0;
                    r.action = ACT_REBUILD;
                end
            end
        end
        return r;
    endfunction

    function automatic logic [47:0] rand48();
        return 48'({$urandom, $urandom});
    endfunction

    task automatic push_event(input logic kind, input logic [TIME_W-1:0] t, input logic fail,
                              input logic [STAGE_W-1:0] st, input logic [GEN_W-1:0] g);
        t_event ev;
        ev.req_type = kind;
        ev.now_time = t;
        ev.link_failed = fail;
        ev.next_stage = st;
        ev.next_gen = g;
        event_q.push_back(ev);
        n_queued++;
    endtask

    task automatic tick_at(input logic [TIME_W-1:0] t, input logic fail);
        push_event(KIND_TICK, t, fail, 4'($urandom_range(15)), rand48());
    endtask

    task automatic progress_at(input logic [TIME_W-1:0] t, input logic [STAGE_W-1:0] st,
                               input logic [GEN_W-1:0] g);
        push_event(KIND_PROGRESS, t, 1'($urandom_range(1)), st, g);
    endtask

    // schedule, rebuild, a run of phase reports, then usually a way out of the attempt
    task automatic queue_session();
        logic [GEN_W-1:0] g;
        int st;
        int steps;
        int i;
        tick_at(tc, 1'b0);
        tc += $urandom_range(17000);
        tick_at(tc, 1'b0);
        tc += 17000;
        tick_at(tc, 1'b0);
        g = rand48();
        if ($urandom_range(19) == 0)
            g = '0;
        else if (g == '0)
            g = 48'd1;
        st = 1;
        steps = $urandom_range(6, 1);
        for (i = 0; i < steps; i++) begin
            tc += $urandom_range(cfg_win >> 2);
            case ($urandom_range(9))
                0: progress_at(tc, 4'($urandom_range(15)), g);
                1: progress_at(tc, 4'(st + 1), g + 1'b1);
                default: begin
                    st += $urandom_range(3, 1);
                    if (st > 12)
                        st = 12;
                    progress_at(tc, 4'(st), g);
                end
            endcase
        end
        case ($urandom_range(3))
            0: tick_at(tc, 1'b1);
            1: begin
                tc += TIME_W'(cfg_win) + 1'b1;
                tick_at(tc, 1'b0);
            end
            2: begin
                tick_at(tc, 1'b0);
                tick_at(tc, 1'b1);
            end
            default: ;
        endcase
        if ($urandom_range(3) == 0) begin
            if ($urandom_range(1))
                progress_at(rand48(), 4'($urandom_range(15)), rand48());
            else
                tick_at(tc, 1'($urandom_range(1)));
        end
    endtask

    task automatic run_random(input int count);
        int stop;
        stop = n_queued + count;
        while (n_queued < stop)
            queue_session();
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WIN_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_wdata <= val;
        case (idx)
            CFG_ENABLE:       cfg_en = val[0];
            CFG_STAGE_WINDOW: cfg_win = val;
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // sender holds off until every result is back
    task automatic drain();
        @(negedge i_clk);
        while (event_q.size() != 0 || s_axis_tvalid || verdict_q.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic note_error(input string msg);
        err_count++;
        if (err_count <= 10)
            $display("mismatch: %s", msg);
    endtask

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                verdict_q.push_back(schedule_event(drv_ev));
            if (!s_axis_tvalid || s_axis_tready) begin
                if (event_q.size() != 0 && $urandom_range(99) >= send_idle) begin
                    drv_ev = event_q.pop_front();
                    s_axis_tuser <= drv_ev.req_type;
                    s_axis_tdata <= {3'b000, drv_ev.next_gen, drv_ev.next_stage,
                                     drv_ev.link_failed, drv_ev.now_time};
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = t_result'(m_axis_tdata[2:0]);
                if (verdict_q.size() == 0) begin
                    note_error($sformatf("unexpected transfer action %0d progress_ok %0d",
                                         got.action, got.progress_ok));
                end else begin
                    want = verdict_q.pop_front();
                    if (got.action !== want.action)
                        note_error($sformatf("action expected %0d got %0d",
                                             want.action, got.action));
                    if (got.progress_ok !== want.progress_ok)
                        note_error($sformatf("progress_ok expected %0d got %0d",
                                             want.progress_ok, got.progress_ok));
                end
            end
            m_axis_tready <= ($urandom_range(99) >= recv_idle);
        end
    end

    initial begin
        #2000000;
        $display("FAILED: results differ");
        $finish;
    end

    initial begin
        send_idle = 20;
        recv_idle = 61;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // schedule off after reset
        tick_at(48'd0, 1'b0);
        progress_at(48'd0, 4'd1, 48'd1);
        drain();

        // enabled but zero window
        write_reg(CFG_ENABLE, 32'd1);
        tick_at(48'd50, 1'b1);
        progress_at(48'd50, 4'd2, 48'd3);
        drain();

        write_reg(CFG_STAGE_WINDOW, 32'd5000);
        progress_at(48'd60, 4'd2, 48'd5);
        tick_at(48'd100, 1'b0);
        tick_at(48'd1099, 1'b0);
        tick_at(48'd1100, 1'b0);
        progress_at(48'd1200, 4'd2, 48'd0);
        progress_at(48'd1200, 4'd1, 48'd7);
        progress_at(48'd1200, STAGE_CONNECTED, 48'd7);
        progress_at(48'd1200, 4'd15, 48'd7);
        progress_at(48'd1200, 4'd3, 48'd7);
        progress_at(48'd1300, 4'd4, 48'd8);
        progress_at(48'd6200, 4'd5, 48'd7);
        progress_at(48'd6199, 4'd9, 48'd7);
        tick_at(48'd6000, 1'b0);
        tick_at(48'd6500, 1'b1);
        tick_at(48'd8500, 1'b0);
        drain();

        // progress with zero window pins the stage deadline to now
        write_reg(CFG_STAGE_WINDOW, 32'd0);
        progress_at(48'd8600, 4'd2, 48'd1);
        progress_at(48'd8600, 4'd3, 48'd1);
        drain();

        // widest window and time at its top
        write_reg(CFG_STAGE_WINDOW, 32'hFFFF_FFFF);
        tick_at(48'd9000, 1'b0);
        tick_at({TIME_W{1'b1}}, 1'b0);
        progress_at({TIME_W{1'b1}}, 4'd9, {GEN_W{1'b1}});
        tick_at({TIME_W{1'b1}}, 1'b0);
        tick_at(48'd0, 1'b1);
        drain();

        tc = 48'd100000;
        write_reg(CFG_STAGE_WINDOW, 32'd5000);
        run_random(120);
        drain();

        send_idle = 61;
        recv_idle = 20;
        write_reg(CFG_STAGE_WINDOW, 32'($urandom_range(50000, 1)));
        run_random(120);
        drain();

        write_reg(CFG_ENABLE, 32'd0);
        run_random(20);
        drain();
        write_reg(CFG_ENABLE, 32'd1);

        send_idle = 0;
        recv_idle = 0;
        write_reg(CFG_STAGE_WINDOW, 32'hFFFF_FFFF);
        run_random(60);
        drain();

        write_reg(CFG_STAGE_WINDOW, 32'd1);
        run_random(60);
        drain();

        repeat (10) @(negedge i_clk);
        if (err_count == 0 && verdict_q.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
